### rtl/core/utf8d_pkg.sv
// Shared types and codes for the UTF-8 stream decoder.
package utf8d_pkg;

    typedef enum logic [2:0] {
        MODE_EMPTY   = 3'b001,
        MODE_PENDING = 3'b010,
        MODE_REPLAY  = 3'b100
    } mode_t;

    localparam logic [1:0] ST_CODE = 2'd0;
    localparam logic [1:0] ST_MORE = 2'd1;
    localparam logic [1:0] ST_RAW  = 2'd2;
    localparam logic [1:0] ST_END  = 2'd3;

    localparam int unsigned VALUE_W = 21;

    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] value;
    } result_t;

endpackage

### rtl/core/utf8d_if.sv
// Valid/ready channel interfaces for decoder requests and results.
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface utf8d_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [utf8d_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

### rtl/core/utf8d_core.sv
// Sequence state and combinational decode of one request.
module utf8d_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic               end_of_input,
    output utf8d_pkg::result_t res
);

    utf8d_pkg::mode_t mode_reg, mode_next;
    logic [1:0]       count_reg, count_next;
    logic [1:0]       need_reg, need_next;
    logic [7:0]       held_reg [3];
    logic [7:0]       held_next [3];

    logic [7:0]       app;
    logic [7:0]       seq [4];
    logic [2:0]       seq_n;
    logic [1:0]       fail_count;
    logic             is_cont;
    logic             dec_ok;
    logic [20:0]      dec_cp;

    function automatic logic [21:0] decode_seq(
        input logic [7:0] s0,
        input logic [7:0] s1,
        input logic [7:0] s2,
        input logic [7:0] s3,
        input logic [2:0] n
    );
        logic [20:0] v;
        logic        ok;
        v  = '0;
        ok = 1'b0;
        unique case (n)
            3'd2:
            begin
                v  = {10'd0, s0[4:0], s1[5:0]};
                ok = (v >= 21'h80);
            end
            3'd3:
            begin
                v  = {5'd0, s0[3:0], s1[5:0], s2[5:0]};
                ok = (v >= 21'h800) && !((v >= 21'hD800) && (v < 21'hE000));
            end
            3'd4:
            begin
                v  = {s0[2:0], s1[5:0], s2[5:0], s3[5:0]};
                ok = (v >= 21'h10000) && (v <= 21'h10FFFF);
            end
            default:
            begin
                v  = '0;
                ok = 1'b0;
            end
        endcase
        return {ok, v};
    endfunction

    assign app     = end_of_input ? 8'h00 : data_byte;
    assign is_cont = !end_of_input && (data_byte[7:6] == 2'b10);

    // Pending bytes followed by the new byte, oldest first.
    assign seq[0] = (count_reg != 2'd0) ? held_reg[0] : app;
    assign seq[1] = (count_reg > 2'd1) ? held_reg[1] : ((count_reg == 2'd1) ? app : 8'h00);
    assign seq[2] = (count_reg == 2'd3) ? held_reg[2] : ((count_reg == 2'd2) ? app : 8'h00);
    assign seq[3] = (count_reg == 2'd3) ? app : 8'h00;
    assign seq_n  = {1'b0, count_reg} + {2'd0, !end_of_input};

    assign fail_count       = (seq_n == 3'd0) ? 2'd0 : 2'(seq_n - 3'd1);
    assign {dec_ok, dec_cp} = decode_seq(seq[0], seq[1], seq[2], seq[3], seq_n);

    always_comb
    begin
        res          = '{status: utf8d_pkg::ST_END, value: '0};
        mode_next    = mode_reg;
        count_next   = count_reg;
        need_next    = need_reg;
        held_next[0] = held_reg[0];
        held_next[1] = held_reg[1];
        held_next[2] = held_reg[2];

        priority if (mode_reg == utf8d_pkg::MODE_PENDING)
        begin
            if (is_cont && (need_reg > 2'd1) && (seq_n < 3'd4))
            begin
                held_next[count_reg] = data_byte;
                count_next           = seq_n[1:0];
                need_next            = need_reg - 2'd1;
                res.status           = utf8d_pkg::ST_MORE;
            end
            else if (is_cont && dec_ok)
            begin
                mode_next  = utf8d_pkg::MODE_EMPTY;
                count_next = 2'd0;
                need_next  = 2'd0;
                res        = '{status: utf8d_pkg::ST_CODE, value: dec_cp};
            end
            else
            begin
                // Broken, invalid or ended sequence: lead byte now, rest held.
                held_next[0] = seq[1];
                held_next[1] = seq[2];
                held_next[2] = seq[3];
                count_next   = fail_count;
                need_next    = 2'd0;
                mode_next    = (fail_count != 2'd0) ? utf8d_pkg::MODE_REPLAY
                                                    : utf8d_pkg::MODE_EMPTY;
                res          = '{status: utf8d_pkg::ST_RAW, value: {13'd0, seq[0]}};
            end
        end
        else if ((mode_reg == utf8d_pkg::MODE_REPLAY) && end_of_input)
        begin
            if (count_reg == 2'd0)
            begin
                mode_next  = utf8d_pkg::MODE_EMPTY;
                need_next  = 2'd0;
                res.status = utf8d_pkg::ST_END;
            end
            else
            begin
                held_next[0] = held_reg[1];
                held_next[1] = held_reg[2];
                count_next   = count_reg - 2'd1;
                if (count_reg == 2'd1)
                begin
                    mode_next = utf8d_pkg::MODE_EMPTY;
                    need_next = 2'd0;
                end
                res = '{status: utf8d_pkg::ST_RAW, value: {13'd0, held_reg[0]}};
            end
        end
        else
        begin
            // Nothing open; a real byte during replay drops the held bytes.
            mode_next  = utf8d_pkg::MODE_EMPTY;
            count_next = 2'd0;
            need_next  = 2'd0;
            if (end_of_input)
            begin
                res.status = utf8d_pkg::ST_END;
            end
            else if (data_byte < 8'h80)
            begin
                res = '{status: utf8d_pkg::ST_CODE, value: {13'd0, data_byte}};
            end
            else if ((data_byte >= 8'hC2) && (data_byte <= 8'hF4))
            begin
                held_next[0] = data_byte;
                count_next   = 2'd1;
                need_next    = (data_byte < 8'hE0) ? 2'd1 :
                               ((data_byte < 8'hF0) ? 2'd2 : 2'd3);
                mode_next    = utf8d_pkg::MODE_PENDING;
                res.status   = utf8d_pkg::ST_MORE;
            end
            else
            begin
                res = '{status: utf8d_pkg::ST_RAW, value: {13'd0, data_byte}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= utf8d_pkg::MODE_EMPTY;
            count_reg <= 2'd0;
            need_reg  <= 2'd0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            need_reg  <= need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held_reg[0] <= held_next[0];
            held_reg[1] <= held_next[1];
            held_reg[2] <= held_next[2];
        end
    end

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == utf8d_pkg::MODE_EMPTY) |-> (count_reg == 2'd0) && (need_reg == 2'd0))
        else $error("empty mode with held bytes or expected bytes");

    a_pending_open: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == utf8d_pkg::MODE_PENDING) |-> (count_reg != 2'd0) && (need_reg != 2'd0))
        else $error("pending sequence without lead byte or expected bytes");

    a_replay_held: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == utf8d_pkg::MODE_REPLAY) |-> (count_reg != 2'd0) && (need_reg == 2'd0))
        else $error("replay mode with nothing held");

endmodule

### rtl/core/utf8_stream_decoder_top.sv
// UTF-8 stream decoder top level: request register, decode core, result register.
// Takes one request per cycle while results are taken and gives exactly one result per request, in order.
// An accepted request sits in the request register until the result register is free
// to take its result; then the sequence state is updated and the result registered
// at the same edge, after which it can be taken.
// Throughput is one request per clock while results are taken; the decode logic
// is a single pass over the registered byte and the 3-byte held-sequence state.
// Held bytes of a broken sequence come out one per later end-of-input request; a real byte drops them.
module utf8_stream_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    utf8d_in_if.sink    in_ch,
    utf8d_out_if.source out_ch
);

    logic               req_valid_reg;
    logic [7:0]         req_byte_reg;
    logic               req_eoi_reg;
    logic               out_valid_reg;
    utf8d_pkg::result_t out_res_reg;
    utf8d_pkg::result_t core_res;
    logic               advance;
    logic               accept;

    assign advance      = req_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !req_valid_reg || advance;
    assign accept       = in_ch.valid && in_ch.ready;

    utf8d_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (req_byte_reg),
        .end_of_input (req_eoi_reg),
        .res          (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_byte_reg <= in_ch.data_byte;
            req_eoi_reg  <= in_ch.end_of_input;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = out_res_reg.status;
    assign out_ch.value  = out_res_reg.value;

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("request left the register without a result");

    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> req_valid_reg)
        else $error("accepted request lost");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((out_res_reg.status == utf8d_pkg::ST_MORE) ||
                          (out_res_reg.status == utf8d_pkg::ST_END))
        |-> (out_res_reg.value == '0))
        else $error("nonzero value with no code point or byte");

    a_raw_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.status == utf8d_pkg::ST_RAW)
        |-> (out_res_reg.value[20:8] == '0))
        else $error("raw result wider than a byte");

endmodule

### dv/utf8_stream_decoder_checker.sv
`timescale 1ns / 100ps
// Result predictor and scoreboard for the UTF-8 stream decoder channels.
module utf8_stream_decoder_checker
(
    input  logic clk,
    input  logic rst_n,
    utf8d_in_if  in_ch,
    utf8d_out_if out_ch,
    output int   fail_count,
    output int   outstanding,
    output int   code_count,
    output int   raw_count,
    output int   end_count
);

    utf8d_pkg::mode_t   dec_mode;
    logic [7:0]         pend_bytes [3];
    int                 pend_count;
    int                 cont_left;
    utf8d_pkg::result_t pending_results [$];

    int fails  = 0;
    int n_code = 0;
    int n_raw  = 0;
    int n_end  = 0;

    function automatic utf8d_pkg::result_t decode_step(input logic [7:0] b, input logic eoi);
        utf8d_pkg::result_t r;
        logic [7:0]         seq [4];
        logic [20:0]        cp;
        logic               ok;
        logic               broken;
        int                 n;
        r      = '0;
        cp     = '0;
        ok     = 1'b0;
        broken = 1'b0;
        n      = 0;
        for (int i = 0; i < 4; i++)
        begin
            seq[i] = 8'h00;
        end
        if (!eoi && dec_mode == utf8d_pkg::MODE_REPLAY)
        begin
            dec_mode   = utf8d_pkg::MODE_EMPTY;
            pend_count = 0;
            cont_left  = 0;
        end
        case (dec_mode)
            utf8d_pkg::MODE_EMPTY:
            begin
                if (eoi)
                begin
                    r.status = utf8d_pkg::ST_END;
                end
                else if (b < 8'h80)
                begin
                    r.status = utf8d_pkg::ST_CODE;
                    r.value  = {13'd0, b};
                end
                else if (b >= 8'hC2 && b <= 8'hF4)
                begin
                    pend_bytes[0] = b;
                    pend_count    = 1;
                    cont_left     = (b < 8'hE0) ? 1 : ((b < 8'hF0) ? 2 : 3);
                    dec_mode      = utf8d_pkg::MODE_PENDING;
                    r.status      = utf8d_pkg::ST_MORE;
                end
                else
                begin
                    r.status = utf8d_pkg::ST_RAW;
                    r.value  = {13'd0, b};
                end
            end
            utf8d_pkg::MODE_PENDING:
            begin
                n = pend_count;
                for (int i = 0; i < n; i++)
                begin
                    seq[i] = pend_bytes[i];
                end
                if (!eoi && b[7:6] == 2'b10)
                begin
                    seq[n] = b;
                    n++;
                    if (cont_left > 1 && n < 4)
                    begin
                        cont_left--;
                        pend_bytes[n-1] = b;
                        pend_count      = n;
                        r.status        = utf8d_pkg::ST_MORE;
                    end
                    else
                    begin
                        case (n)
                            2:
                            begin
                                cp = {10'd0, seq[0][4:0], seq[1][5:0]};
                                ok = (cp >= 21'h80);
                            end
                            3:
                            begin
                                cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
                                ok = (cp >= 21'h800) && !(cp >= 21'hD800 && cp < 21'hE000);
                            end
                            4:
                            begin
                                cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
                                ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
                            end
                            default: ok = 1'b0;
                        endcase
                        if (ok)
                        begin
                            dec_mode   = utf8d_pkg::MODE_EMPTY;
                            pend_count = 0;
                            cont_left  = 0;
                            r.status   = utf8d_pkg::ST_CODE;
                            r.value    = cp;
                        end
                        else
                        begin
                            broken = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (!eoi)
                    begin
                        seq[n] = b;
                        n++;
                    end
                    broken = 1'b1;
                end
                if (broken)
                begin
                    // lead byte goes out now, the rest waits for end marks
                    r.status   = utf8d_pkg::ST_RAW;
                    r.value    = {13'd0, seq[0]};
                    pend_count = (n > 1) ? n - 1 : 0;
                    for (int i = 0; i < pend_count; i++)
                    begin
                        pend_bytes[i] = seq[i+1];
                    end
                    cont_left = 0;
                    dec_mode  = (pend_count != 0) ? utf8d_pkg::MODE_REPLAY
                                                  : utf8d_pkg::MODE_EMPTY;
                end
            end
            default:
            begin
                if (pend_count == 0)
                begin
                    dec_mode  = utf8d_pkg::MODE_EMPTY;
                    cont_left = 0;
                    r.status  = utf8d_pkg::ST_END;
                end
                else
                begin
                    r.status      = utf8d_pkg::ST_RAW;
                    r.value       = {13'd0, pend_bytes[0]};
                    pend_bytes[0] = pend_bytes[1];
                    pend_bytes[1] = pend_bytes[2];
                    pend_count--;
                    if (pend_count == 0)
                    begin
                        dec_mode  = utf8d_pkg::MODE_EMPTY;
                        cont_left = 0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        utf8d_pkg::result_t want;
        if (!rst_n)
        begin
            dec_mode   = utf8d_pkg::MODE_EMPTY;
            pend_count = 0;
            cont_left  = 0;
            pending_results.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (out_ch.status == utf8d_pkg::ST_CODE)
                begin
                    n_code++;
                end
                else if (out_ch.status == utf8d_pkg::ST_RAW)
                begin
                    n_raw++;
                end
                else if (out_ch.status == utf8d_pkg::ST_END)
                begin
                    n_end++;
                end
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: status %0d value 0x%0h",
                           out_ch.status, out_ch.value);
                    fails++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, out_ch.status);
                        fails++;
                    end
                    if (out_ch.value !== want.value)
                    begin
                        $error("value mismatch: expected 0x%0h, got 0x%0h",
                               want.value, out_ch.value);
                        fails++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                pending_results.push_back(decode_step(in_ch.data_byte, in_ch.end_of_input));
            end
        end
        fail_count  <= fails;
        outstanding <= pending_results.size();
        code_count  <= n_code;
        raw_count   <= n_raw;
        end_count   <= n_end;
    end

endmodule

### dv/utf8_stream_decoder_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the UTF-8 stream decoder: clock, reset, request stimulus and verdict.
module utf8_stream_decoder_top_tb;

    localparam int TOTAL_REQS     = 1576;
    localparam int CALM_REQS      = 300;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic idle_on;
    int   stall_left = 0;
    int   quiet = 0;
    int   sent = 0;

    int fail_count;
    int outstanding;
    int code_count;
    int raw_count;
    int end_count;

    utf8d_in_if  in_ch();
    utf8d_out_if out_ch();

    utf8_stream_decoder_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    utf8_stream_decoder_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .code_count  (code_count),
        .raw_count   (raw_count),
        .end_count   (end_count)
    );

    always #5 clk = ~clk;

    // result-side backpressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 13);
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    task automatic put_request(input logic [7:0] b, input logic eoi);
        int gap;
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.end_of_input <= eoi;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    initial
    begin
        logic [8:0]  dir_q [$];
        logic [8:0]  burst [$];
        logic [20:0] cp;
        logic [7:0]  lead;
        logic [7:0]  b;
        int          pick;
        int          len;
        int          cnt;

        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = 8'h00;
        in_ch.end_of_input = 1'b0;
        idle_on            = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // {end_of_input, data_byte}
        dir_q = '{9'h000, 9'h07F, 9'h080, 9'h0FF,
                  9'h0E0, 9'h09F, 9'h0BF, 9'h100,
                  9'h0ED, 9'h0A0, 9'h080,
                  9'h0C3, 9'h041, 9'h100, 9'h1FF,
                  9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
                  9'h0F4, 9'h090, 9'h080, 9'h080,
                  9'h0F0, 9'h090, 9'h100};
        foreach (dir_q[i])
        begin
            put_request(dir_q[i][7:0], dir_q[i][8]);
        end

        while (sent < TOTAL_REQS)
        begin
            idle_on <= (sent < TOTAL_REQS - CALM_REQS) && ((sent / 160) % 2 == 0);
            burst.delete();
            pick = $urandom_range(0, 99);
            lead = 8'($urandom_range(8'hC2, 8'hF4));
            len  = (lead < 8'hE0) ? 2 : ((lead < 8'hF0) ? 3 : 4);
            if (pick < 40)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        cp = 21'($urandom_range(0, 21'h7F));
                        burst.push_back({1'b0, cp[7:0]});
                    end
                    1:
                    begin
                        cp = 21'($urandom_range(21'h80, 21'h7FF));
                        burst.push_back({1'b0, 3'b110, cp[10:6]});
                        burst.push_back({1'b0, 2'b10, cp[5:0]});
                    end
                    2:
                    begin
                        cp = 21'($urandom_range(21'h800, 21'hFFFF));
                        if (cp >= 21'hD800 && cp < 21'hE000)
                        begin
                            cp = cp ^ 21'h1000;
                        end
                        burst.push_back({1'b0, 4'b1110, cp[15:12]});
                        burst.push_back({1'b0, 2'b10, cp[11:6]});
                        burst.push_back({1'b0, 2'b10, cp[5:0]});
                    end
                    default:
                    begin
                        cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                        burst.push_back({1'b0, 5'b11110, cp[20:18]});
                        burst.push_back({1'b0, 2'b10, cp[17:12]});
                        burst.push_back({1'b0, 2'b10, cp[11:6]});
                        burst.push_back({1'b0, 2'b10, cp[5:0]});
                    end
                endcase
            end
            else if (pick < 85)
            begin
                // full, truncated or broken sequence with random content
                burst.push_back({1'b0, lead});
                cnt = (pick < 65) ? len - 1 : $urandom_range(0, len - 2);
                repeat (cnt) burst.push_back({1'b0, 8'($urandom_range(8'h80, 8'hBF))});
                if (pick >= 75)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b[7:6] == 2'b10)
                    begin
                        b = b ^ ($urandom_range(0, 1) ? 8'h80 : 8'h40);
                    end
                    burst.push_back({1'b0, b});
                end
                cnt = (pick < 65) ? $urandom_range(0, 1) : $urandom_range(1, 4);
                repeat (cnt) burst.push_back({1'b1, 8'($urandom_range(0, 255))});
            end
            else
            begin
                cnt = $urandom_range(1, 4);
                repeat (cnt)
                begin
                    burst.push_back({($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255))});
                end
            end
            foreach (burst[i])
            begin
                put_request(burst[i][7:0], burst[i][8]);
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests, 26 of them directed, with idle bursts on both sides",
                 sent);
        $display("results seen: %0d code points, %0d raw bytes, %0d end marks",
                 code_count, raw_count, end_count);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
